[hdl/ipv4_classful_address_parser_unit_assert.svh]
// Assertion macros shared by the checker of the address parser unit.
`ifndef IPV4_CLASSFUL_ADDRESS_PARSER_UNIT_ASSERT_SVH
`define IPV4_CLASSFUL_ADDRESS_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled in reset.
`define ICAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled in reset.
`define ICAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/icap_pkg.sv]
// Package with the types and constants of the IPv4 classful address parser.
package icap_pkg;

    localparam logic [7:0] MAX_CHARS   = 8'd39;
    localparam int         QUEUE_DEPTH = 2;
    localparam int         OUT_W       = 232;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [7:0] LIMIT_A = 8'd127;
    localparam logic [7:0] LIMIT_B = 8'd191;
    localparam logic [7:0] LIMIT_C = 8'd223;
    localparam logic [7:0] LIMIT_D = 8'd239;

    localparam logic [31:0] MASK_A  = 32'hFF00_0000;
    localparam logic [31:0] MASK_B  = 32'hFFFF_0000;
    localparam logic [31:0] MASK_C  = 32'hFFFF_FF00;
    localparam logic [31:0] MASK_DE = 32'h0000_0000;

    localparam logic [31:0] HOSTS_A  = 32'd16777214;
    localparam logic [31:0] HOSTS_B  = 32'd65534;
    localparam logic [31:0] HOSTS_C  = 32'd254;
    localparam logic [31:0] HOSTS_DE = 32'd4294967294;

    typedef enum logic [2:0] {
        CLASS_A = 3'd0,
        CLASS_B = 3'd1,
        CLASS_C = 3'd2,
        CLASS_D = 3'd3,
        CLASS_E = 3'd4
    } t_class;

    // One parsed string as handed from the front to the back.
    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    // Occupancy flags of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hdl/icap_front.sv]
// Front part: tokenizes the character stream and hands one record per string to the queue.
module icap_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    input  icap_pkg::t_q_status i_q_status,
    output logic              o_push,
    output icap_pkg::t_rec    o_rec
);

    logic [7:0]       r_char_cnt, n_char_cnt;
    logic [2:0]       r_tok_cnt,  n_tok_cnt,  f_tok_cnt;
    logic [7:0]       r_tok_len,  n_tok_len;
    logic             r_lead_zero, n_lead_zero;
    logic [8:0]       r_tok_val,  n_tok_val;
    logic             r_err,      n_err,      f_err;
    logic [7:0]       r_oct [4];
    logic [7:0]       n_oct [4];
    logic [7:0]       f_oct [4];
    logic             take;
    logic             is_digit;
    logic [11:0]      prod;
    logic             accept;

    assign o_ready  = !i_q_status.full;
    assign accept   = i_valid && o_ready;
    assign take     = r_char_cnt < icap_pkg::MAX_CHARS;
    assign is_digit = (i_ch >= icap_pkg::CH_ZERO) && (i_ch <= icap_pkg::CH_NINE);
    assign prod     = ({3'b000, r_tok_val} << 3) + ({3'b000, r_tok_val} << 1)
                    + {8'h00, i_ch[3:0]};

    always_comb begin
        n_char_cnt  = (r_char_cnt == 8'hFF) ? r_char_cnt : r_char_cnt + 8'd1;
        n_tok_cnt   = r_tok_cnt;
        n_tok_len   = r_tok_len;
        n_lead_zero = r_lead_zero;
        n_tok_val   = r_tok_val;
        n_err       = r_err;
        n_oct       = r_oct;
        if (take) begin
            if (i_ch == icap_pkg::CH_DOT) begin
                if (r_tok_len != 8'd0 && r_tok_cnt < 3'd4) begin
                    if (r_tok_val > 9'd255) begin
                        n_err = 1'b1;
                    end
                    n_oct[r_tok_cnt[1:0]] = r_tok_val[7:0];
                    n_tok_cnt = r_tok_cnt + 3'd1;
                end
                n_tok_len   = 8'd0;
                n_lead_zero = 1'b0;
                n_tok_val   = 9'd0;
            end else if (r_tok_cnt < 3'd4) begin
                if (!is_digit) begin
                    n_err = 1'b1;
                end else begin
                    if (r_tok_len != 8'd0 && r_lead_zero) begin
                        n_err = 1'b1;
                    end
                    if (r_tok_len == 8'd0 && i_ch == icap_pkg::CH_ZERO) begin
                        n_lead_zero = 1'b1;
                    end
                    n_tok_val = (prod > 12'd256) ? 9'd256 : prod[8:0];
                end
                if (r_tok_len != 8'hFF) begin
                    n_tok_len = r_tok_len + 8'd1;
                end
            end
        end

        // The final character also closes the token in progress.
        f_tok_cnt = n_tok_cnt;
        f_err     = n_err;
        f_oct     = n_oct;
        if (n_tok_len != 8'd0 && n_tok_cnt < 3'd4) begin
            if (n_tok_val > 9'd255) begin
                f_err = 1'b1;
            end
            f_oct[n_tok_cnt[1:0]] = n_tok_val[7:0];
            f_tok_cnt = n_tok_cnt + 3'd1;
        end
    end

    assign o_push      = accept && i_last;
    assign o_rec.valid = !f_err && (f_tok_cnt == 3'd4);
    assign o_rec.addr  = {f_oct[0], f_oct[1], f_oct[2], f_oct[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_char_cnt  <= 8'd0;
            r_tok_cnt   <= 3'd0;
            r_tok_len   <= 8'd0;
            r_lead_zero <= 1'b0;
            r_tok_val   <= 9'd0;
            r_err       <= 1'b0;
            r_oct       <= '{default: 8'd0};
        end else if (accept) begin
            r_char_cnt  <= n_char_cnt;
            r_tok_cnt   <= n_tok_cnt;
            r_tok_len   <= n_tok_len;
            r_lead_zero <= n_lead_zero;
            r_tok_val   <= n_tok_val;
            r_err       <= n_err;
            r_oct       <= n_oct;
        end
    end

endmodule

[hdl/icap_queue.sv]
// Short register queue that decouples the front part from the back part.
module icap_queue #(
    parameter int DEPTH = icap_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  icap_pkg::t_rec      i_rec,
    input  logic                i_pop,
    output icap_pkg::t_rec      o_rec,
    output icap_pkg::t_q_status o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    icap_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_rec          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

[hdl/icap_back.sv]
// Back part: derives the classful fields of one record and holds them in the output register.
module icap_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  icap_pkg::t_rec              i_rec,
    input  icap_pkg::t_q_status         i_q_status,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [icap_pkg::OUT_W-1:0]  o_data
);

    logic                        r_valid;
    logic [icap_pkg::OUT_W-1:0]  r_data, n_data;
    icap_pkg::t_class            cls;
    logic [31:0]                 mask, hosts, network, host_part, bcast, first_h, last_h;
    logic [7:0]                  oct0;

    assign oct0  = i_rec.addr[31:24];
    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    always_comb begin
        priority if (oct0 <= icap_pkg::LIMIT_A) begin
            cls   = icap_pkg::CLASS_A;
            mask  = icap_pkg::MASK_A;
            hosts = icap_pkg::HOSTS_A;
        end else if (oct0 <= icap_pkg::LIMIT_B) begin
            cls   = icap_pkg::CLASS_B;
            mask  = icap_pkg::MASK_B;
            hosts = icap_pkg::HOSTS_B;
        end else if (oct0 <= icap_pkg::LIMIT_C) begin
            cls   = icap_pkg::CLASS_C;
            mask  = icap_pkg::MASK_C;
            hosts = icap_pkg::HOSTS_C;
        end else if (oct0 <= icap_pkg::LIMIT_D) begin
            cls   = icap_pkg::CLASS_D;
            mask  = icap_pkg::MASK_DE;
            hosts = icap_pkg::HOSTS_DE;
        end else begin
            cls   = icap_pkg::CLASS_E;
            mask  = icap_pkg::MASK_DE;
            hosts = icap_pkg::HOSTS_DE;
        end
        network   = i_rec.addr & mask;
        host_part = i_rec.addr & ~mask;
        bcast     = network | ~mask;
        first_h   = {network[31:8], network[7:0] + 8'd1};
        last_h    = {bcast[31:8], bcast[7:0] - 8'd1};
        if (i_rec.valid) begin
            n_data = {4'h0, hosts, last_h, first_h, bcast, host_part, network, mask,
                      cls, 1'b1};
        end else begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[hdl/ipv4_classful_address_parser_unit.sv]
// Top level of the IPv4 classful address parser unit.
// The unit takes one character item per clock cycle, including the cycle after a string's
// final character, so text streams through with no gaps; the character tokenizer in the
// front part is the only per-character loop. A string's record enters the queue at the
// edge that accepts its final character and then moves into the output register, which
// drives the master side, once that register is free. The queue of QUEUE_DEPTH records lets
// the front keep taking characters while results wait to be taken; the front stalls only
// while the queue is full.
module ipv4_classful_address_parser_unit #(
    parameter int QUEUE_DEPTH = icap_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // ch
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // valid_res, addr_class, mask, network, host_part, broadcast, first_host, last_host,
    // total_hosts, zero fill
    output logic [icap_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    icap_pkg::t_rec      push_rec, head_rec;
    icap_pkg::t_q_status q_status;
    logic                push, pop;

    icap_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_ch       (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_rec      (push_rec)
    );

    icap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    icap_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (head_rec),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata)
    );

endmodule

[hdl/icap_checker.sv]
// Port-level checker for the address parser unit and its bind statement.
`include "ipv4_classful_address_parser_unit_assert.svh"

module icap_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_m_tvalid,
    input logic                       i_m_tready,
    input logic [icap_pkg::OUT_W-1:0] i_m_tdata
);

    logic [2:0]  cls;
    logic [31:0] mask, network, bcast, hosts;
    logic        stalled, res_ok, res_bad, is_de, de_ok;

    assign cls     = i_m_tdata[3:1];
    assign mask    = i_m_tdata[35:4];
    assign network = i_m_tdata[67:36];
    assign bcast   = i_m_tdata[131:100];
    assign hosts   = i_m_tdata[227:196];
    assign stalled = i_m_tvalid && !i_m_tready;
    assign res_ok  = i_m_tvalid && i_m_tdata[0];
    assign res_bad = i_m_tvalid && !i_m_tdata[0];
    assign is_de   = (cls == icap_pkg::CLASS_D) || (cls == icap_pkg::CLASS_E);
    assign de_ok   = (mask == icap_pkg::MASK_DE) && (hosts == icap_pkg::HOSTS_DE);

    `ICAP_ASSERT_NEXT(a_stall_hold, stalled, i_m_tvalid && $stable(i_m_tdata), "Stalled item changed.")
    `ICAP_ASSERT_NOW(a_invalid_zero, res_bad, i_m_tdata[227:1] == '0, "Invalid item not zero.")
    `ICAP_ASSERT_NOW(a_class_range, res_ok, cls <= icap_pkg::CLASS_E, "Class out of range.")
    `ICAP_ASSERT_NOW(a_class_de, res_ok && is_de, de_ok, "Class D or E item is wrong.")
    `ICAP_ASSERT_NOW(a_bcast, res_ok, bcast == (network | ~mask), "Broadcast is wrong.")

endmodule

bind ipv4_classful_address_parser_unit icap_checker u_icap_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
